>>> hw/rtl/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions of the SHA-256 engine.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_LEN,
        ST_OUT
    } t_state;

    // what follows the state addition of a compression
    typedef enum logic [1:0] {
        AFT_NONE,
        AFT_PAD,
        AFT_LEN,
        AFT_DONE
    } t_after;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

>>> hw/rtl/sha_front.sv
// ----------------------------------------------------------------------------
// sha_front
// Input side: accepts requests, drops empty ones, queues the rest.
// ----------------------------------------------------------------------------
module sha_front #(
    parameter int DEPTH = sha_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  sha_pkg::t_item i_item,
    output logic           o_qvalid,
    output sha_pkg::t_item o_qitem,
    input  logic           i_qpop
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    sha_pkg::t_item r_mem [DEPTH];
    logic [AW:0]    r_wptr, r_rptr;
    logic           w_full, w_push;

    assign w_full   = (r_wptr[AW-1:0] == r_rptr[AW-1:0]) && (r_wptr[AW] != r_rptr[AW]);
    assign o_ready  = !w_full;
    assign o_qvalid = (r_wptr != r_rptr);
    assign o_qitem  = r_mem[r_rptr[AW-1:0]];
    // a request with neither byte nor end is taken and discarded
    assign w_push   = i_valid && !w_full && (i_item.byte_present || i_item.end_of_message);

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr[AW-1:0]] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_qpop && o_qvalid) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

endmodule

>>> hw/rtl/sha_core.sv
// ----------------------------------------------------------------------------
// sha_core
// Back end: block packing, padding, 64-round compression and digest output.
// ----------------------------------------------------------------------------
module sha_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_qvalid,
    input  sha_pkg::t_item i_qitem,
    output logic           o_qpop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [31:0]    o_digest_word,
    output logic [2:0]     o_word_number,
    output logic           o_last_word
);
    sha_pkg::t_state r_state, n_state;
    sha_pkg::t_after r_after, n_after;
    logic [31:0]     r_hash [8];
    logic [31:0]     n_hash [8];
    logic [31:0]     r_v [8];
    logic [31:0]     n_v [8];
    logic [31:0]     r_w [16];
    logic [31:0]     n_w [16];
    logic [5:0]      r_fill, n_fill;
    logic [63:0]     r_bits, n_bits;
    logic [5:0]      r_rnd, n_rnd;
    logic [2:0]      r_idx, n_idx;

    logic [31:0] w_t1, w_t2, w_wnew;

    assign o_valid       = (r_state == sha_pkg::ST_OUT);
    assign o_digest_word = r_hash[r_idx];
    assign o_word_number = r_idx;
    assign o_last_word   = (r_idx == 3'd7);
    assign o_qpop        = (r_state == sha_pkg::ST_IDLE) && i_qvalid;

    assign w_t1 = r_v[7] + sha_pkg::bsig1(r_v[4])
                + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
                + sha_pkg::K[r_rnd] + r_w[0];
    assign w_t2 = sha_pkg::bsig0(r_v[0])
                + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    assign w_wnew = sha_pkg::ssig1(r_w[14]) + r_w[9] + sha_pkg::ssig0(r_w[1]) + r_w[0];

    always_comb begin
        n_state = r_state;
        n_after = r_after;
        n_hash  = r_hash;
        n_v     = r_v;
        n_w     = r_w;
        n_fill  = r_fill;
        n_bits  = r_bits;
        n_rnd   = r_rnd;
        n_idx   = r_idx;
        case (r_state)
            sha_pkg::ST_IDLE: begin
                if (i_qvalid) begin
                    if (i_qitem.byte_present) begin
                        n_w[r_fill[5:2]][(5'd3 - {3'b000, r_fill[1:0]}) * 8 +: 8] =
                            i_qitem.data_byte;
                        n_bits = r_bits + 64'd8;
                        n_fill = r_fill + 6'd1;
                        if (r_fill == 6'd63) begin
                            n_v     = r_hash;
                            n_rnd   = '0;
                            n_state = sha_pkg::ST_ROUND;
                            n_after = i_qitem.end_of_message ? sha_pkg::AFT_PAD
                                                             : sha_pkg::AFT_NONE;
                        end else if (i_qitem.end_of_message) begin
                            n_state = sha_pkg::ST_PAD;
                        end
                    end else begin
                        n_state = sha_pkg::ST_PAD;
                    end
                end
            end
            sha_pkg::ST_PAD: begin
                for (int j = 0; j < 16; j++) begin
                    for (int b = 0; b < 4; b++) begin
                        if (6'(j * 4 + b) == r_fill) begin
                            n_w[j][(3 - b) * 8 +: 8] = sha_pkg::PAD_BYTE;
                        end else if (6'(j * 4 + b) > r_fill) begin
                            n_w[j][(3 - b) * 8 +: 8] = 8'h00;
                        end
                    end
                end
                // length fits only if the pad byte lands below byte 56
                if (r_fill < 6'd56) begin
                    n_w[14] = r_bits[63:32];
                    n_w[15] = r_bits[31:0];
                    n_after = sha_pkg::AFT_DONE;
                end else begin
                    n_after = sha_pkg::AFT_LEN;
                end
                n_v     = r_hash;
                n_rnd   = '0;
                n_state = sha_pkg::ST_ROUND;
            end
            sha_pkg::ST_LEN: begin
                for (int j = 0; j < 14; j++) begin
                    n_w[j] = '0;
                end
                n_w[14] = r_bits[63:32];
                n_w[15] = r_bits[31:0];
                n_v     = r_hash;
                n_rnd   = '0;
                n_after = sha_pkg::AFT_DONE;
                n_state = sha_pkg::ST_ROUND;
            end
            sha_pkg::ST_ROUND: begin
                n_v[7] = r_v[6];
                n_v[6] = r_v[5];
                n_v[5] = r_v[4];
                n_v[4] = r_v[3] + w_t1;
                n_v[3] = r_v[2];
                n_v[2] = r_v[1];
                n_v[1] = r_v[0];
                n_v[0] = w_t1 + w_t2;
                // message schedule as a 16-word sliding window
                for (int j = 0; j < 15; j++) begin
                    n_w[j] = r_w[j + 1];
                end
                n_w[15] = w_wnew;
                n_rnd   = r_rnd + 6'd1;
                if (r_rnd == 6'd63) begin
                    n_state = sha_pkg::ST_ADD;
                end
            end
            sha_pkg::ST_ADD: begin
                for (int j = 0; j < 8; j++) begin
                    n_hash[j] = r_hash[j] + r_v[j];
                end
                case (r_after)
                    sha_pkg::AFT_PAD:  n_state = sha_pkg::ST_PAD;
                    sha_pkg::AFT_LEN:  n_state = sha_pkg::ST_LEN;
                    sha_pkg::AFT_DONE: begin
                        n_idx   = '0;
                        n_state = sha_pkg::ST_OUT;
                    end
                    default:           n_state = sha_pkg::ST_IDLE;
                endcase
            end
            sha_pkg::ST_OUT: begin
                if (i_ready) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        n_hash  = sha_pkg::IV;
                        n_fill  = '0;
                        n_bits  = '0;
                        n_state = sha_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = sha_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_v <= n_v;
        r_w <= n_w;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha_pkg::ST_IDLE;
            r_after <= sha_pkg::AFT_NONE;
            r_hash  <= sha_pkg::IV;
            r_fill  <= '0;
            r_bits  <= '0;
            r_rnd   <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
            r_hash  <= n_hash;
            r_fill  <= n_fill;
            r_bits  <= n_bits;
            r_rnd   <= n_rnd;
            r_idx   <= n_idx;
        end
    end

endmodule

>>> hw/rtl/sha256_hash_engine.sv
// ----------------------------------------------------------------------------
// sha256_hash_engine
// Streaming SHA-256: bytes in, eight digest words out per message.
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready) carries one request: an optional byte
// (i_byte_present) and an end-of-message flag. Requests with neither are
// dropped. Output channel (o_valid/i_ready) carries digest words H0..H7,
// numbered, with o_last_word on the eighth.
// A short request queue sits in front of the hashing core, so requests keep
// being taken while the core compresses or while digest words wait.
// Bytes enter the block one per cycle while the core is idle; each full
// 64-byte block is then compressed (64 rounds, one state addition; the load
// rides on the last byte) by the single-round compression unit.
// End of message: a padding step and a compression, plus a length block and a
// second compression when the length spills into a second block, then 8 words
// at one per cycle while the receiver is ready.
// A stalled receiver holds the current word; the core waits, the queue fills.
// Reset (synchronous, active low) empties the queue and restores the
// initial hash values, zero length and an empty block.
// ----------------------------------------------------------------------------
module sha256_hash_engine #(
    parameter int QUEUE_DEPTH = sha_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_number,
    output logic        o_last_word
);
    sha_pkg::t_item w_item, w_qitem;
    logic           w_qvalid, w_qpop;

    assign w_item.data_byte      = i_data_byte;
    assign w_item.byte_present   = i_byte_present;
    assign w_item.end_of_message = i_end_of_message;

    sha_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_item   (w_item),
        .o_qvalid (w_qvalid),
        .o_qitem  (w_qitem),
        .i_qpop   (w_qpop)
    );

    sha_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_qvalid      (w_qvalid),
        .i_qitem       (w_qitem),
        .o_qpop        (w_qpop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_digest_word (o_digest_word),
        .o_word_number (o_word_number),
        .o_last_word   (o_last_word)
    );

endmodule

>>> hw/rtl/sha_checker.sv
// ----------------------------------------------------------------------------
// sha_checker
// Port-level checks of the digest output sequence.
// ----------------------------------------------------------------------------
module sha_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_digest_word,
    input logic [2:0]  o_word_number,
    input logic        o_last_word
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_digest_word))
        else $error("digest word changed while stalled");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_word == (o_word_number == 3'd7)))
        else $error("last flag out of step with word number");

    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_word |=>
            o_valid && (o_word_number == 3'($past(o_word_number) + 3'd1)))
        else $error("digest burst broken");

    a_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> (o_word_number == 3'd0))
        else $error("digest burst does not start at word 0");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind sha256_hash_engine sha_checker u_sha_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_digest_word (o_digest_word),
    .o_word_number (o_word_number),
    .o_last_word   (o_last_word)
);

>>> tb/sha256_hash_engine_test.sv
// ----------------------------------------------------------------------------
// sha256_hash_engine_test
// Streams directed requests and messages of boundary and random length into the
// engine byte by byte, checks each digest word against a bench SHA-256 predictor.
// ----------------------------------------------------------------------------
module sha256_hash_engine_test;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_number;
        logic        last_word;
    } t_word;

    typedef struct {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
        logic       has_digest;
        logic [31:0] h0;
    } t_row;

    localparam int WATCHDOG_LIMIT = 5000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_data_byte = '0;
    logic        i_byte_present = 1'b0;
    logic        i_end_of_message = 1'b0;
    logic        i_ready = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_number;
    logic        o_last_word;

    sha256_hash_engine u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_data_byte      (i_data_byte),
        .i_byte_present   (i_byte_present),
        .i_end_of_message (i_end_of_message),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_digest_word    (o_digest_word),
        .o_word_number    (o_word_number),
        .o_last_word      (o_last_word)
    );

    always #6 i_clk = ~i_clk;

    // predictor state
    logic [31:0] chain_h [8];
    logic [7:0]  msg_block [64];
    int          block_fill;
    logic [63:0] bit_count;

    t_word       digest_q [$];
    int          mismatch_count = 0;
    int          digest_count = 0;
    int          request_count = 0;
    int          idle_cycles = 0;
    bit          no_idle = 1'b0;
    bit          timed_out = 1'b0;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, s0, s1;
        for (int i = 0; i < 16; i++)
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        for (int i = 16; i < 64; i++) begin
            s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
        end
        v = chain_h;
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::K[i] + w[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain_h[i] += v[i];
    endtask

    task automatic restart_hash();
        chain_h = sha_pkg::IV;
        block_fill = 0;
        bit_count = '0;
    endtask

    // absorb one request; queue the eight digest words when the message ends
    task automatic hash_request(input logic [7:0] b, input logic present, input logic eom);
        if (present) begin
            msg_block[block_fill] = b;
            bit_count += 64'd8;
            block_fill++;
            if (block_fill == 64) begin
                compress_block();
                block_fill = 0;
            end
        end
        if (eom) begin
            msg_block[block_fill] = sha_pkg::PAD_BYTE;
            block_fill++;
            if (block_fill > 56) begin
                for (int i = block_fill; i < 64; i++) msg_block[i] = 8'h00;
                compress_block();
                block_fill = 0;
            end
            for (int i = block_fill; i < 56; i++) msg_block[i] = 8'h00;
            for (int i = 0; i < 8; i++) msg_block[63-i] = bit_count[8*i +: 8];
            compress_block();
            for (int i = 0; i < 8; i++)
                digest_q.push_back('{chain_h[i], 3'(i), i == 7});
            restart_hash();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                   input logic [31:0] act_v);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch %s: expected %h, got %h", what, exp_v, act_v);
    endtask

    // digest word receiver and checker
    always @(posedge i_clk) begin
        t_word exp_w;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (digest_q.size() == 0) begin
                    report_mismatch("unexpected word", 32'h0, o_digest_word);
                end else begin
                    exp_w = digest_q.pop_front();
                    digest_count++;
                    if (o_digest_word !== exp_w.digest_word)
                        report_mismatch("digest_word", exp_w.digest_word, o_digest_word);
                    if (o_word_number !== exp_w.word_number)
                        report_mismatch("word_number", 32'(exp_w.word_number),
                                        32'(o_word_number));
                    if (o_last_word !== exp_w.last_word)
                        report_mismatch("last_word", 32'(exp_w.last_word),
                                        32'(o_last_word));
                end
            end
            i_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 14);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT && !timed_out) begin
            timed_out <= 1'b1;
            $display("watchdog expired");
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // valid stays up between back-to-back requests; callers drop it before waiting
    task automatic send_request(input logic [7:0] b, input logic present, input logic eom);
        while (!no_idle && $urandom_range(99) < 14) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_data_byte      <= b;
        i_byte_present   <= present;
        i_end_of_message <= eom;
        do @(posedge i_clk); while (!o_ready);
        request_count++;
        hash_request(b, present, eom);
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++) begin
            // occasional empty request in the middle
            if ($urandom_range(19) == 0) send_request(8'($urandom), 1'b0, 1'b0);
            if (i == len - 1 && $urandom_range(1))
                send_request(8'($urandom), 1'b1, 1'b1);
            else
                send_request(8'($urandom), 1'b1, 1'b0);
        end
        if (len == 0 || !i_end_of_message) send_request(8'($urandom), 1'b0, 1'b1);
    endtask

    // directed table; h0 given where it is a well known digest
    t_row dir_rows [] = '{
        '{8'h00, 1'b0, 1'b1, 1'b1, 32'he3b0c442},  // empty message
        '{8'h5a, 1'b0, 1'b0, 1'b0, 32'h0},         // neither byte nor end
        '{8'h61, 1'b1, 1'b0, 1'b0, 32'h0},         // "abc"
        '{8'h62, 1'b1, 1'b0, 1'b0, 32'h0},
        '{8'h63, 1'b1, 1'b1, 1'b1, 32'hba7816bf},  // byte and end together
        '{8'hff, 1'b1, 1'b1, 1'b0, 32'h0},
        '{8'h00, 1'b1, 1'b0, 1'b0, 32'h0},
        '{8'h00, 1'b0, 1'b1, 1'b0, 32'h0}
    };

    initial begin
        int len;
        t_word first_w;
        int bound_lens [4] = '{55, 56, 63, 64};
        restart_hash();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            send_request(dir_rows[r].data_byte, dir_rows[r].byte_present,
                         dir_rows[r].end_of_message);
            if (dir_rows[r].has_digest) begin
                first_w = digest_q[digest_q.size() - 8];
                if (first_w.digest_word !== dir_rows[r].h0)
                    report_mismatch("known digest", dir_rows[r].h0, first_w.digest_word);
            end
        end
        // lengths around the padding boundaries
        foreach (bound_lens[k]) begin
            send_message(bound_lens[k]);
        end

        // hold off until every digest word is out
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (digest_q.size() != 0) @(posedge i_clk);

        while (request_count < 500) begin
            no_idle = (request_count > 300 && request_count < 370);
            len = ($urandom_range(9) == 0) ? $urandom_range(130) : $urandom_range(12);
            send_message(len);
        end
        no_idle = 1'b0;
        i_valid <= 1'b0;

        @(posedge i_clk);
        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("%0d requests sent, %0d digest words checked, incl. empty and boundary",
                 request_count, digest_count);
        if (mismatch_count == 0 && digest_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/sha_pkg.sv
hw/rtl/sha_front.sv
hw/rtl/sha_core.sv
hw/rtl/sha256_hash_engine.sv
hw/rtl/sha_checker.sv
tb/sha256_hash_engine_test.sv
